// ----- src/pixel_samples_to_float_rgb_core_defines.svh -----
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef PIXEL_SAMPLES_TO_FLOAT_RGB_CORE_DEFINES_SVH
`define PIXEL_SAMPLES_TO_FLOAT_RGB_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/psf_pkg.sv -----
// Types and constants for the sample to float converter.
// No dependencies.
package psf_pkg;
    localparam logic [1:0] FMT_U8     = 2'd0;
    localparam logic [1:0] FMT_U16    = 2'd1;
    localparam logic [1:0] FMT_HALF   = 2'd2;
    localparam logic [1:0] FMT_SINGLE = 2'd3;
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_GREY   = 1'b1;
    // significands of the float32 constants 1/255 and 1/65535, hidden bit set
    localparam logic [23:0] MANT_U8  = 24'h808081;
    localparam logic [7:0]  EXP_U8   = 8'd119;
    localparam logic [23:0] MANT_U16 = 24'h800080;
    localparam logic [7:0]  EXP_U16  = 8'd111;
    localparam logic [7:0]  HALF_EXP_BIAS = 8'd112;
    localparam int STAGES = 3;
endpackage

// ----- src/psf_channel.sv -----
// One color channel: three-stage conversion of a raw sample to float32.
// Depends on psf_pkg; enables come from the top-level pipeline control.
module psf_channel
(
    input  logic        clk,
    input  logic [2:0]  stage_en,
    input  logic [1:0]  fmt,
    input  logic [31:0] sample,
    output logic [31:0] result
);
    // stage 1: normalize integer, decode half
    logic [1:0]  fmt1_reg;
    logic [15:0] norm1_reg;     // integer shifted so msb is set
    logic [4:0]  lz1_reg;
    logic        zero1_reg;
    logic [31:0] pass1_reg;     // half/single result
    logic [15:0] norm1_next;
    logic [4:0]  lz1_next;
    logic [15:0] ival;
    logic [31:0] half_next;
    logic [15:0] h;
    logic [9:0]  hman;
    logic [4:0]  hlz;
    logic [9:0]  hman_sh;

    always_comb
    begin
        ival = (fmt == psf_pkg::FMT_U8) ? {8'd0, sample[7:0]} : sample[15:0];
        lz1_next = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (ival[i])
            begin
                lz1_next = 5'(15 - i);
            end
        end
        norm1_next = ival << lz1_next[3:0];
        h = sample[15:0];
        hman = h[9:0];
        hlz = 5'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hman[i])
            begin
                hlz = 5'(9 - i);
            end
        end
        hman_sh = hman << (hlz + 5'd1);
        if (h[14:10] == 5'h1f)
        begin
            half_next = {h[15], 8'hff, hman, 13'd0};
        end
        else if (h[14:10] != 5'd0)
        begin
            half_next = {h[15], 8'(h[14:10]) + psf_pkg::HALF_EXP_BIAS, hman, 13'd0};
        end
        else if (hman == 10'd0)
        begin
            half_next = {h[15], 31'd0};
        end
        else
        begin
            half_next = {h[15], 8'd113 - 8'(hlz) - 8'd1, hman_sh, 13'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            fmt1_reg  <= fmt;
            norm1_reg <= norm1_next;
            lz1_reg   <= lz1_next;
            zero1_reg <= (ival == 16'd0);
            pass1_reg <= (fmt == psf_pkg::FMT_HALF) ? half_next : sample;
        end
    end

    // stage 2: multiply significands
    logic [1:0]  fmt2_reg;
    logic [39:0] prod2_reg;
    logic [4:0]  lz2_reg;
    logic        zero2_reg;
    logic [31:0] pass2_reg;
    logic [23:0] cmant;

    always_comb
    begin
        cmant = (fmt1_reg == psf_pkg::FMT_U8) ? psf_pkg::MANT_U8 : psf_pkg::MANT_U16;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            fmt2_reg  <= fmt1_reg;
            prod2_reg <= norm1_reg * cmant;
            lz2_reg   <= lz1_reg;
            zero2_reg <= zero1_reg;
            pass2_reg <= pass1_reg;
        end
    end

    // stage 3: round to nearest even, pack
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        top;
    logic [23:0] m;
    logic        rnd;
    logic        sticky;
    logic [24:0] mr;
    logic [7:0]  ex;
    logic [7:0]  cexp;

    always_comb
    begin
        top = prod2_reg[39];
        m = top ? prod2_reg[39:16] : prod2_reg[38:15];
        rnd = top ? prod2_reg[15] : prod2_reg[14];
        sticky = top ? (prod2_reg[14:0] != 15'd0) : (prod2_reg[13:0] != 14'd0);
        mr = {1'b0, m} + 25'(rnd && (sticky || m[0]));
        cexp = (fmt2_reg == psf_pkg::FMT_U8) ? psf_pkg::EXP_U8 : psf_pkg::EXP_U16;
        ex = cexp + 8'd15 - 8'(lz2_reg) + 8'(top) + 8'(mr[24]);
        if (fmt2_reg == psf_pkg::FMT_HALF || fmt2_reg == psf_pkg::FMT_SINGLE)
        begin
            result_next = pass2_reg;
        end
        else if (zero2_reg)
        begin
            result_next = 32'd0;
        end
        else
        begin
            result_next = {1'b0, ex, mr[24] ? mr[23:1] : mr[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
endmodule

// ----- src/pixel_samples_to_float_rgb_core.sv -----
// Pixel sample to float32 RGB converter, top level.
// Each pixel passes through the stage 1, stage 2 and stage 3 registers to the output.
// Throughput: one pixel per cycle while out_ready allows; the stall-capable pipeline has three stages.
// Reset: rst_n async low clears valid bits and sets format u8, grey off.
// Depends on psf_pkg and psf_channel.
module pixel_samples_to_float_rgb_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_first,
    input  logic [31:0] sample_second,
    input  logic [31:0] sample_third,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] red_bits,
    output logic [31:0] green_bits,
    output logic [31:0] blue_bits
);
    logic [1:0] fmt_reg;
    logic       grey_reg;
    logic [2:0] valid_reg;
    logic [2:0] valid_next;
    logic [2:0] stage_en;
    logic [31:0] red_int;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= psf_pkg::FMT_U8;
            grey_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                psf_pkg::REG_FORMAT: fmt_reg  <= cfg_data;
                psf_pkg::REG_GREY:   grey_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        stage_en[2] = !valid_reg[2] || out_ready;
        stage_en[1] = !valid_reg[1] || stage_en[2];
        stage_en[0] = !valid_reg[0] || stage_en[1];
        valid_next = valid_reg;
        if (stage_en[2])
        begin
            valid_next[2] = valid_reg[1];
        end
        if (stage_en[1])
        begin
            valid_next[1] = valid_reg[0];
        end
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
    end

    assign in_ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    psf_channel u_red
    (
        .clk(clk), .stage_en(stage_en), .fmt(fmt_reg),
        .sample(sample_first), .result(red_int)
    );
    psf_channel u_green
    (
        .clk(clk), .stage_en(stage_en), .fmt(fmt_reg),
        .sample(grey_reg ? sample_first : sample_second), .result(green_bits)
    );
    psf_channel u_blue
    (
        .clk(clk), .stage_en(stage_en), .fmt(fmt_reg),
        .sample(grey_reg ? sample_first : sample_third), .result(blue_bits)
    );

    assign red_bits  = red_int;
    assign out_valid = valid_reg[psf_pkg::STAGES - 1];
endmodule

// ----- src/psf_checker.sv -----
// Port-level checks for the converter, bound to the top level.
// Depends on the defines header.
`include "pixel_samples_to_float_rgb_core_defines.svh"
module psf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] red_bits
);
    `PSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_bits))
    `PSF_ASSERT_IMP(a_ready_free, !out_valid, in_ready)
    `PSF_ASSERT_NEXT(a_stall_full, out_valid && !out_ready && !in_ready, !in_ready || out_ready)
endmodule

bind pixel_samples_to_float_rgb_core psf_checker u_psf_checker
(
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .red_bits(red_bits)
);

// ----- tb/tb_pixel_samples_to_float_rgb_core.sv -----
// Testbench for pixel_samples_to_float_rgb_core: drives pixels and config writes and
// checks each output transaction against an integer-exact model of the conversion.
// Depends on psf_pkg and the core RTL.
module tb_pixel_samples_to_float_rgb_core;

    class rgb_scoreboard;
        logic [1:0] fmt;
        logic grey;
        logic [95:0] pending[$];
        int errors;

        function new();
            fmt = psf_pkg::FMT_U8;
            grey = 1'b0;
            errors = 0;
        endfunction

        // x * float(1/255 or 1/65535), rounded to nearest even
        function logic [31:0] scale_unorm(logic [31:0] x, logic [23:0] mant,
                                          logic [7:0] ex);
            logic [63:0] prod;
            logic [63:0] sig;
            logic [63:0] rem;
            logic [63:0] half;
            int p;
            int sh;
            int bexp;
            if (x == 0)
                return 32'h0;
            prod = 64'(x) * 64'(mant);
            p = 0;
            for (int i = 0; i < 64; i++)
                if (prod[i])
                    p = i;
            sh = p - 23;
            sig = prod >> sh;
            if (sh > 0)
            begin
                rem = prod & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && sig[0]))
                    sig = sig + 1;
            end
            if (sig == (64'd1 << 24))
            begin
                sig = sig >> 1;
                p = p + 1;
            end
            bexp = p + int'(ex) - 150 + 127;
            return {1'b0, bexp[7:0], sig[22:0]};
        endfunction

        function logic [31:0] widen_half(logic [15:0] h);
            logic [31:0] sign;
            logic [4:0] ex;
            logic [10:0] man;
            int lead;
            sign = {h[15], 31'h0};
            ex = h[14:10];
            man = {1'b0, h[9:0]};
            if (ex == 5'h1f)
                return sign | 32'h7f800000 | (32'(man[9:0]) << 13);
            if (ex != 0)
                return sign | ((32'(ex) + 32'(psf_pkg::HALF_EXP_BIAS)) << 23)
                       | (32'(man[9:0]) << 13);
            if (man == 0)
                return sign;
            lead = 0;
            while (!man[10])
            begin
                man = man << 1;
                lead++;
            end
            return sign | (32'(113 - lead) << 23) | (32'(man[9:0]) << 13);
        endfunction

        function logic [31:0] to_float(logic [31:0] raw);
            case (fmt)
                psf_pkg::FMT_U8:
                    return scale_unorm({24'h0, raw[7:0]}, psf_pkg::MANT_U8, psf_pkg::EXP_U8);
                psf_pkg::FMT_U16:
                    return scale_unorm({16'h0, raw[15:0]}, psf_pkg::MANT_U16,
                                       psf_pkg::EXP_U16);
                psf_pkg::FMT_HALF:
                    return widen_half(raw[15:0]);
                default:
                    return raw;
            endcase
        endfunction

        function void note_pixel(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2);
            logic [31:0] r;
            logic [31:0] g;
            logic [31:0] b;
            r = to_float(s0);
            g = grey ? r : to_float(s1);
            b = grey ? r : to_float(s2);
            pending.push_back({r, g, b});
        endfunction

        task report(string what, logic [95:0] want, logic [95:0] got);
            $display("ERROR %s: expected %h got %h (fmt %0d grey %0d)",
                     what, want, got, fmt, grey);
            errors++;
        endtask

        task check_rgb(logic [31:0] r, logic [31:0] g, logic [31:0] b);
            logic [95:0] e;
            if (pending.size() == 0)
            begin
                report("unexpected output transaction", 0, {r, g, b});
                return;
            end
            e = pending.pop_front();
            if (r !== e[95:64])
                report("red mismatch", e[95:64], r);
            if (g !== e[63:32])
                report("green mismatch", e[63:32], g);
            if (b !== e[31:0])
                report("blue mismatch", e[31:0], b);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = 1'b0;
    logic [1:0] cfg_data = 2'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] sample_first = 32'h0;
    logic [31:0] sample_second = 32'h0;
    logic [31:0] sample_third = 32'h0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;

    rgb_scoreboard sb = new();
    int idle_mode = 0;
    int hold_cycles = 0;
    int cycles = 0;

    pixel_samples_to_float_rgb_core dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else if (idle_mode == 2)
            out_ready <= ($urandom_range(99) >= 63);
        else if (idle_mode == 3)
            out_ready <= ($urandom_range(99) >= 7);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_rgb(red_bits, green_bits, blue_bits);

    task automatic write_reg(logic [0:0] idx, logic [1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == psf_pkg::REG_FORMAT)
            sb.fmt = val;
        else
            sb.grey = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2);
        int gap;
        gap = (idle_mode == 1) ? 63 : (idle_mode == 3) ? 7 : 0;
        while ($urandom_range(99) < gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_first <= s0;
        sample_second <= s1;
        sample_third <= s2;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(s0, s1, s2);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_sample(logic [1:0] fmt);
        logic [31:0] v;
        v = $urandom;
        if (fmt == psf_pkg::FMT_HALF && $urandom_range(1))
            v[14:10] = $urandom_range(1) ? 5'h00 : 5'h1f;
        else if (fmt == psf_pkg::FMT_SINGLE && $urandom_range(3) == 0)
            v[30:23] = $urandom_range(1) ? 8'h00 : 8'hff;
        else if (fmt == psf_pkg::FMT_U8 && $urandom_range(3) == 0)
            v[7:0] = $urandom_range(1) ? 8'hff : 8'h00;
        else if (fmt == psf_pkg::FMT_U16 && $urandom_range(3) == 0)
            v[15:0] = $urandom_range(1) ? 16'hffff : 16'h0000;
        return v;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] directed[$];
        logic [1:0] fmt;
        logic [1:0] gval;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            fmt = ph[1:0];
            gval = (ph == 5) ? 2'b11 : (ph == 6) ? 2'b10 : {1'b0, ph >= 4 && ph < 8};
            write_reg(psf_pkg::REG_FORMAT, fmt);
            write_reg(psf_pkg::REG_GREY, gval);
            idle_mode = ph % 4;
            if (ph < 4)
            begin
                case (fmt)
                    psf_pkg::FMT_U8:
                        directed = '{32'h0, 32'hff, 32'hffffff00, 32'hffffffff, 32'h80};
                    psf_pkg::FMT_U16:
                        directed = '{32'h0, 32'hffff, 32'hffff0000, 32'h1, 32'h8000};
                    psf_pkg::FMT_HALF:
                        directed = '{32'h0000, 32'h8000, 32'h0001, 32'h83ff, 32'h0400,
                                     32'h7bff, 32'h7c00, 32'hfc00, 32'h7e01};
                    default:
                        directed = '{32'h0, 32'h80000000, 32'h7f800000, 32'hffffffff};
                endcase
                for (int i = 0; i < directed.size(); i++)
                    send_pixel(directed[i], ~directed[i], directed[i] ^ 32'h5555aaaa);
            end
            if (ph == 8)
                hold_cycles = 300;
            for (int i = 0; i < 120; i++)
                send_pixel(rand_sample(fmt), rand_sample(fmt), rand_sample(fmt));
        end
        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
